[rtl/core/lnlms_pkg.sv]
// shared types, constants and register codes of the leaky nlms filter
`default_nettype none

package lnlms_pkg;

    localparam int HIST_DEPTH = 512;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int MAX_TAPS   = 128;
    localparam int TAP_AW     = $clog2(MAX_TAPS);
    localparam int W_BITS     = 32;
    localparam int W_FRAC     = W_BITS - 2;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_TAP_DELAY   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEP_SIZE   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LEAK_FACTOR = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TAP_COUNT   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OUTPUT_MODE = 3'd4;

    // register reset values
    localparam logic [8:0]  RST_TAP_DELAY   = 9'd16;
    localparam logic [15:0] RST_STEP_SIZE   = 16'd655;
    localparam logic [15:0] RST_LEAK_FACTOR = 16'd0;
    localparam logic [7:0]  RST_TAP_COUNT   = 8'd64;
    localparam logic        RST_OUTPUT_MODE = 1'b0;

    // divider sizes: |mu*err| << 31 over power + 1
    localparam int DIVIDEND_BITS = 62;
    localparam int DIVISOR_BITS  = 39;

    typedef struct packed {
        logic           clr;
        logic           load;
        logic           rd;
        logic           mul1;
        logic           acc1;
        logic           err;
        logic           div_start;
        logic           gain;
        logic           mul2;
        logic           mul3;
        logic           wr2;
        logic           out;
        logic [HIST_AW-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] taps;
        logic       div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/core/lnlms_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module lnlms_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [lnlms_pkg::DIVIDEND_BITS-1:0] i_dividend,
    input  wire logic [lnlms_pkg::DIVISOR_BITS-1:0]  i_divisor,
    output logic                                     o_done,
    output logic [lnlms_pkg::DIVIDEND_BITS-1:0]      o_quotient
);

    localparam int NB = lnlms_pkg::DIVIDEND_BITS;
    localparam int DB = lnlms_pkg::DIVISOR_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_q, n_q;
    logic [DB-1:0] r_rem, n_rem;
    logic [DB-1:0] r_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DB:0]   trial;
    logic [DB:0]   diff;

    always_comb begin
        trial  = {r_rem, r_q[NB-1]};
        diff   = trial - {1'b0, r_div};
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(NB);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (!diff[DB]) begin
                n_rem = diff[DB-1:0];
                n_q   = {r_q[NB-2:0], 1'b1};
            end else begin
                n_rem = trial[DB-1:0];
                n_q   = {r_q[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

[rtl/core/lnlms_datapath.sv]
// history and weight memories, multiply-accumulate and update arithmetic
`default_nettype none

module lnlms_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lnlms_pkg::t_dp_cmd             i_cmd,
    output lnlms_pkg::t_dp_sts                  o_sts,
    input  wire logic signed [15:0]             i_sample_in,
    output logic signed [15:0]                  o_sample_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [lnlms_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [lnlms_pkg::CFG_DW-1:0]   i_cfg_data
);

    localparam int HD = lnlms_pkg::HIST_DEPTH;
    localparam int HA = lnlms_pkg::HIST_AW;
    localparam int MT = lnlms_pkg::MAX_TAPS;
    localparam int TA = lnlms_pkg::TAP_AW;
    localparam int WB = lnlms_pkg::W_BITS;
    localparam int WF = lnlms_pkg::W_FRAC;
    localparam int ACCW = WB + 16 + TA + 1;
    localparam int PRDW = ACCW - WF;
    localparam int ERRW = PRDW + 1;
    localparam int POWW = 31 + TA;

    function automatic logic signed [15:0] sat16(input logic signed [ERRW-1:0] v);
        if (v > ERRW'(32767)) begin
            return 16'sh7fff;
        end else if (v < -ERRW'(32768)) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // configuration registers
    logic [8:0]  r_tap_delay;
    logic [15:0] r_step_size;
    logic [15:0] r_leak;
    logic [7:0]  r_tap_count;
    logic        r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_delay <= lnlms_pkg::RST_TAP_DELAY;
            r_step_size <= lnlms_pkg::RST_STEP_SIZE;
            r_leak      <= lnlms_pkg::RST_LEAK_FACTOR;
            r_tap_count <= lnlms_pkg::RST_TAP_COUNT;
            r_mode      <= lnlms_pkg::RST_OUTPUT_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lnlms_pkg::REG_TAP_DELAY:   r_tap_delay <= i_cfg_data[8:0];
                lnlms_pkg::REG_STEP_SIZE:   r_step_size <= i_cfg_data;
                lnlms_pkg::REG_LEAK_FACTOR: r_leak      <= i_cfg_data;
                lnlms_pkg::REG_TAP_COUNT:   r_tap_count <= i_cfg_data[7:0];
                lnlms_pkg::REG_OUTPUT_MODE: r_mode      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_sts.taps = (r_tap_count > 8'(MT)) ? 8'(MT) : r_tap_count;

    // memories
    logic signed [15:0]   r_hist [HD];
    logic signed [WB-1:0] r_wt   [MT];
    logic signed [15:0]   r_hist_q;
    logic signed [WB-1:0] r_w_q;
    logic [HA-1:0]        r_wp;
    logic [HA-1:0]        hist_wa;
    logic [HA-1:0]        hist_ra;
    logic signed [15:0]   hist_wd;
    logic signed [WB-1:0] w_new;

    assign hist_wa = i_cmd.clr ? i_cmd.idx : r_wp;
    assign hist_wd = i_cmd.clr ? 16'sd0 : i_sample_in;
    assign hist_ra = i_cmd.idx + r_tap_delay + r_wp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.load) begin
            r_hist[hist_wa] <= hist_wd;
        end
        if (i_cmd.rd) begin
            r_hist_q <= r_hist[hist_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_wt[i_cmd.idx[TA-1:0]] <= '0;
        end else if (i_cmd.wr2) begin
            r_wt[i_cmd.idx[TA-1:0]] <= w_new;
        end
        if (i_cmd.rd) begin
            r_w_q <= r_wt[i_cmd.idx[TA-1:0]];
        end
    end

    // first pass: prediction and power
    logic signed [15:0]      r_x;
    logic signed [WB+15:0]   r_prod;
    logic signed [31:0]      r_sq;
    logic signed [ACCW-1:0]  r_acc;
    logic [POWW-1:0]         r_pow;
    logic signed [PRDW-1:0]  r_pred;
    logic signed [ERRW-1:0]  r_err;
    logic signed [15:0]      errs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_sample_in;
            r_acc <= '0;
            r_pow <= '0;
        end else if (i_cmd.acc1) begin
            r_acc <= r_acc + ACCW'(r_prod);
            r_pow <= r_pow + POWW'(r_sq[30:0]);
        end
        if (i_cmd.mul1) begin
            r_prod <= r_w_q * r_hist_q;
            r_sq   <= r_hist_q * r_hist_q;
        end
        if (i_cmd.err) begin
            r_pred <= r_acc[ACCW-1:WF];
            r_err  <= ERRW'(r_x) - ERRW'($signed(r_acc[ACCW-1:WF]));
        end
    end

    // step gain: mu * err * 2^31 / (power + 1)
    logic signed [32:0] mu_err;
    logic [32:0]        mu_err_mag;
    logic [lnlms_pkg::DIVIDEND_BITS-1:0] dividend;
    logic [lnlms_pkg::DIVISOR_BITS-1:0]  divisor;
    logic [lnlms_pkg::DIVIDEND_BITS-1:0] quot;
    logic               r_neg;
    logic [47:0]        gain_mag;
    logic signed [48:0] r_gain;

    assign errs       = sat16(r_err);
    assign mu_err     = $signed({1'b0, r_step_size}) * errs;
    assign mu_err_mag = mu_err[32] ? 33'(-mu_err) : 33'(mu_err);
    assign dividend   = {mu_err_mag[30:0], 31'd0};
    assign divisor    = lnlms_pkg::DIVISOR_BITS'(r_pow) + 1'b1;

    lnlms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (o_sts.div_done),
        .o_quotient (quot)
    );

    // clamp magnitude to 2^47
    assign gain_mag = (quot > lnlms_pkg::DIVIDEND_BITS'(48'h8000_0000_0000))
                      ? 48'h8000_0000_0000 : quot[47:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= errs[15];
        end
        if (i_cmd.gain) begin
            r_gain <= r_neg ? -$signed({1'b0, gain_mag}) : $signed({1'b0, gain_mag});
        end
    end

    // second pass: leaky update
    logic signed [WB+16:0] r_p1;
    logic signed [64:0]    r_p2;
    logic signed [WB+17:0] r_dec;
    logic signed [WB+18:0] w_sum;
    logic signed [WB+18:0] w_max;
    logic signed [WB+18:0] w_min;

    assign w_max = (WB+19)'({1'b0, {(WB-1){1'b1}}});
    assign w_min = -w_max - (WB+19)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_p1 <= r_w_q * $signed({1'b0, r_step_size});
            r_p2 <= r_gain * r_hist_q;
        end
        if (i_cmd.mul3) begin
            r_dec <= $signed(r_p1[WB+16:16]) * $signed({1'b0, r_leak});
        end
    end

    always_comb begin
        w_sum = (WB+19)'(r_w_q) - (WB+19)'($signed(r_dec[WB+17:16]))
              + (WB+19)'($signed(r_p2[64:47-WF]));
        if (w_sum > w_max) begin
            w_new = w_max[WB-1:0];
        end else if (w_sum < w_min) begin
            w_new = w_min[WB-1:0];
        end else begin
            w_new = w_sum[WB-1:0];
        end
    end

    // result and write pointer
    logic signed [15:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.out) begin
            r_wp <= r_wp - 1'b1;
        end
        if (i_cmd.out) begin
            r_out <= r_mode ? sat16(ERRW'(r_pred)) : sat16(r_err);
        end
    end

    assign o_sample_out = r_out;

endmodule

`default_nettype wire

[rtl/core/lnlms_ctrl.sv]
// sequencing state machine of the leaky nlms filter
`default_nettype none

module lnlms_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lnlms_pkg::t_dp_cmd      o_cmd,
    input  wire lnlms_pkg::t_dp_sts i_sts
);

    localparam int HA = lnlms_pkg::HIST_AW;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_RD1      = 13'b0000000000100,
        S_MUL1     = 13'b0000000001000,
        S_ACC1     = 13'b0000000010000,
        S_ERR      = 13'b0000000100000,
        S_DIV_GO   = 13'b0000001000000,
        S_DIV_WAIT = 13'b0000010000000,
        S_GAIN     = 13'b0000100000000,
        S_RD2      = 13'b0001000000000,
        S_MUL2     = 13'b0010000000000,
        S_MUL3     = 13'b0100000000000,
        S_WR2      = 13'b1000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [HA-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          r_out_pend, n_out_pend;
    logic          last_tap;
    logic          out_fire;

    assign last_tap = ({1'b0, r_cnt} + 1'b1) == (HA+1)'(i_sts.taps);
    // result goes out once the output register is free
    assign out_fire = r_out_pend && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_pend  = r_out_pend;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = r_cnt;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (out_fire) begin
            o_cmd.out   = 1'b1;
            n_out_pend  = 1'b0;
            n_out_valid = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == {HA{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !r_out_pend;
                if (i_in_valid && !r_out_pend) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = (i_sts.taps == 8'd0) ? S_ERR : S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_ACC1;
            end
            S_ACC1: begin
                o_cmd.acc1 = 1'b1;
                if (last_tap) begin
                    n_cnt   = '0;
                    n_state = S_ERR;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RD1;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_cnt      = '0;
                if (i_sts.taps == 8'd0) begin
                    n_out_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                if (last_tap) begin
                    n_cnt      = '0;
                    n_out_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RD2;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_out_pend  <= n_out_pend;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/leaky_nlms_adaptive_filter.sv]
// top level of the leaky normalized lms adaptive line enhancer
// usage:
//  - input channel i_in_valid / o_in_ready carries one signed q1.15 word
//    i_sample_in; output channel o_out_valid / i_out_ready carries the
//    saturated q1.15 word o_sample_out, one result per input word
//  - config port: i_cfg_we writes i_cfg_data into register i_cfg_addr
//    (0 tap delay, 1 step size, 2 leak, 3 tap count, 4 output mode);
//    other indexes are ignored; write only while the block is idle
//  - the prediction pass reads, multiplies and accumulates one tap at a
//    time through the single history port, then the sequencer waits on the
//    bit-serial gain divider, and the weight update pass reads, forms the
//    products and the leak decay, and writes back one tap at a time
//  - one word is processed at a time; the next word is taken as soon as
//    the previous result has moved into the output register
//  - after reset a clearing pass over all 512 history entries zeroes the
//    history and the weights; o_in_ready stays low until it ends
//  - if the receiver stalls, the result waits in the output register and
//    at most one further finished result is held inside before input stops
`default_nettype none

module leaky_nlms_adaptive_filter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [15:0]           i_sample_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [15:0]                o_sample_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [lnlms_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [lnlms_pkg::CFG_DW-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    lnlms_pkg::t_dp_cmd cmd;
    lnlms_pkg::t_dp_sts sts;

    lnlms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // memories and arithmetic
    lnlms_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the leaky normalized lms adaptive filter
`timescale 1ns / 1ps

// models the filter one word at a time and holds the expected output words
class nlms_scoreboard;
    longint hist[lnlms_pkg::HIST_DEPTH];
    longint wt[lnlms_pkg::MAX_TAPS];
    int unsigned wpos;
    int unsigned tap_delay, step_size, leak_factor, tap_count, output_mode;
    logic signed [15:0] expected_words[$];
    int errors;

    function new();
        foreach (hist[i]) hist[i] = 0;
        foreach (wt[i]) wt[i] = 0;
        wpos        = 0;
        tap_delay   = lnlms_pkg::RST_TAP_DELAY;
        step_size   = lnlms_pkg::RST_STEP_SIZE;
        leak_factor = lnlms_pkg::RST_LEAK_FACTOR;
        tap_count   = lnlms_pkg::RST_TAP_COUNT;
        output_mode = lnlms_pkg::RST_OUTPUT_MODE;
        errors      = 0;
    endfunction

    function void set_reg(logic [lnlms_pkg::CFG_AW-1:0] idx, logic [15:0] val);
        case (idx)
            lnlms_pkg::REG_TAP_DELAY:   tap_delay   = val[8:0];
            lnlms_pkg::REG_STEP_SIZE:   step_size   = val;
            lnlms_pkg::REG_LEAK_FACTOR: leak_factor = val;
            lnlms_pkg::REG_TAP_COUNT:   tap_count   = val[7:0];
            lnlms_pkg::REG_OUTPUT_MODE: output_mode = val[0];
            default: ;
        endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_input(logic signed [15:0] x_in);
        longint x, s, acc, pred, err, errs, gain, w, decay, delta, power, wmax;
        int unsigned taps;
        x     = x_in;
        taps  = tap_count > lnlms_pkg::MAX_TAPS ? lnlms_pkg::MAX_TAPS : tap_count;
        wmax  = (longint'(1) <<< (lnlms_pkg::W_BITS - 1)) - 1;
        acc   = 0;
        power = 0;
        hist[wpos] = x;
        for (int j = 0; j < taps; j++) begin
            s = hist[(j + tap_delay + wpos) % lnlms_pkg::HIST_DEPTH];
            power += s * s;
            acc   += wt[j] * s;
        end
        pred = acc >>> lnlms_pkg::W_FRAC;
        err  = x - pred;
        errs = clamp(err, -32768, 32767);
        gain = (longint'(step_size) * errs * (longint'(1) <<< 31)) / (power + 1);
        gain = clamp(gain, -(longint'(1) <<< 47), longint'(1) <<< 47);
        for (int j = 0; j < taps; j++) begin
            s     = hist[(j + tap_delay + wpos) % lnlms_pkg::HIST_DEPTH];
            w     = wt[j];
            decay = ((w * longint'(step_size)) >>> 16) * longint'(leak_factor) >>> 16;
            delta = (gain * s) >>> (47 - lnlms_pkg::W_FRAC);
            wt[j] = clamp(w - decay + delta, -wmax - 1, wmax);
        end
        wpos = (wpos + lnlms_pkg::HIST_DEPTH - 1) % lnlms_pkg::HIST_DEPTH;
        expected_words.push_back(16'(clamp(output_mode ? pred : err, -32768, 32767)));
    endfunction

    function void check_output(logic signed [15:0] got);
        logic signed [15:0] exp_word;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected output word %0d", $time, got);
            errors++;
            return;
        end
        exp_word = expected_words.pop_front();
        if (got !== exp_word) begin
            $display("%0t: sample_out mismatch expected %0d actual %0d", $time, exp_word, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 7 * lnlms_pkg::MAX_TAPS + 150;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [15:0]            i_sample_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [15:0]            o_sample_out;
    logic                          i_cfg_we;
    logic [lnlms_pkg::CFG_AW-1:0]  i_cfg_addr;
    logic [lnlms_pkg::CFG_DW-1:0]  i_cfg_data;

    nlms_scoreboard sb = new();

    // idle rates in percent for each side, changed between phases
    int tx_idle, rx_idle;
    // long receiver hold-off requested by the stimulus
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int tone_phase;

    leaky_nlms_adaptive_filter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // receiver: random stalls or a long hold-off, checks every accepted word
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            sb.check_output(o_sample_out);
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // offer one word, with random idle cycles first; valid stays up between words when no idle cycle is drawn
    task send_word(input logic signed [15:0] value);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(value);
    endtask

    // wait until every expected word has come out and the core is quiet
    task drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(input logic [lnlms_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task configure(input int dly, input int mu, input int leak, input int taps, input int mode);
        write_reg(lnlms_pkg::REG_TAP_DELAY, 16'(dly));
        write_reg(lnlms_pkg::REG_STEP_SIZE, 16'(mu));
        write_reg(lnlms_pkg::REG_LEAK_FACTOR, 16'(leak));
        write_reg(lnlms_pkg::REG_TAP_COUNT, 16'(taps));
        write_reg(lnlms_pkg::REG_OUTPUT_MODE, 16'(mode));
    endtask

    // mostly a noisy periodic tone so the filter has something to lock onto
    function automatic logic signed [15:0] pick_sample(int period, int amp);
        int tri_val;
        if ($urandom_range(0, 99) < 25) return 16'($urandom);
        tone_phase = (tone_phase + 1) % period;
        tri_val = (tone_phase < period / 2) ? tone_phase : period - tone_phase;
        return 16'(((tri_val * 4 - period) * amp) / (period + 1)
                   + $signed($urandom_range(0, 63)) - 32);
    endfunction

    task random_phase(input int n_items, input int taps_max);
        int period, amp;
        drain();
        configure($urandom_range(0, 384), $urandom_range(0, 99) < 20 ? 65535 : $urandom_range(0, 8000),
                  $urandom_range(0, 99) < 30 ? $urandom_range(0, 65535) : 0,
                  $urandom_range(1, taps_max), $urandom_range(0, 1));
        period = $urandom_range(4, 40);
        amp    = $urandom_range(100, 32000);
        repeat (n_items) send_word(pick_sample(period, amp));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample_in  = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        tx_idle      = 12;
        rx_idle      = 52;
        hold_request = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        tone_phase   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings with field extremes
        send_word(16'sh7fff);
        send_word(-16'sh8000);
        send_word(16'sh0000);
        send_word(16'sh0001);
        send_word(-16'sh0001);
        // zero taps: prediction zero, weights untouched
        drain();
        configure(0, 65535, 0, 0, 1);
        send_word(16'sh1234);
        send_word(-16'sh8000);
        // tap count above the maximum, delay wrapping the history, big step
        drain();
        configure(511, 65535, 65535, 255, 0);
        repeat (4) begin
            send_word(16'sh7fff);
            send_word(-16'sh8000);
        end
        // full length line at a delay of 384, prediction output
        drain();
        configure(384, 65535, 0, 128, 1);
        repeat (4) send_word(16'(($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000));
        // ignored index and zero step
        drain();
        write_reg(3'd5, 16'hffff);
        write_reg(3'd7, 16'h0001);
        configure(1, 0, 65535, 2, 0);
        repeat (4) send_word(16'($urandom));

        // random phases over three idle schedules
        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                tx_idle = 52;
                rx_idle = 12;
            end
            if (p == 8) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (p == 9) begin
                // long hold-off: the core fills and stops taking input
                drain();
                hold_request = 3000;
            end
            if (p == 10) random_phase(20, 128);
            else random_phase(90, 16);
        end

        drain();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[leaky_nlms_adaptive_filter.f]
rtl/core/lnlms_pkg.sv
rtl/core/lnlms_div.sv
rtl/core/lnlms_datapath.sv
rtl/core/lnlms_ctrl.sv
rtl/core/leaky_nlms_adaptive_filter.sv
tb/sv/testbench.sv
